/* rtl/lfbc_pkg.sv */
// Shared types, constants and the hour-slot to pixel-position map for the LED frame block.
// Used by lfbc_front, lfbc_queue, lfbc_back and led_frame_with_blink_cursor; depends on nothing.
package lfbc_pkg;

    localparam int PIXEL_COUNT = 25;
    localparam int POS_W       = $clog2(PIXEL_COUNT);
    localparam int SLOT_W      = 5;
    localparam int CHAN_W      = 8;
    localparam int COLOR_W     = 3 * CHAN_W;
    localparam int OPCODE_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAN_W-1:0]  GREY_LEVEL = 8'd124;
    localparam logic [COLOR_W-1:0] GREY_RGB   = {GREY_LEVEL, GREY_LEVEL, GREY_LEVEL};
    localparam logic [COLOR_W-1:0] BLACK_RGB  = '0;

    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(PIXEL_COUNT - 1);
    localparam logic [SLOT_W-1:0] FIRST_SLOT  = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] RESET_SLOT  = SLOT_W'(1);
    localparam logic [POS_W-1:0]  LAST_POS    = POS_W'(PIXEL_COUNT - 1);

    localparam logic [OPCODE_W-1:0] OP_SET_COLOR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_ADVANCE   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PLACE     = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TICK      = 2'd3;

    localparam logic [POS_W-1:0] POS_TABLE [PIXEL_COUNT] = '{
        5'd24,
        5'd23, 5'd22, 5'd21, 5'd20, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd14, 5'd13, 5'd12,
        5'd11, 5'd10, 5'd5,  5'd6,  5'd7,  5'd8,  5'd9,  5'd4,  5'd3,  5'd2,  5'd1,  5'd0
    };

    typedef enum logic [1:0] {
        KIND_SET     = 2'd0,
        KIND_ADVANCE = 2'd1,
        KIND_PLACE   = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [SLOT_W-1:0]    slot;
        logic [POS_W-1:0]     pos;
        logic [COLOR_W-1:0]   color;
    } t_cmd;

    function automatic logic [POS_W-1:0] position_of(input logic [SLOT_W-1:0] slot);
        logic [POS_W-1:0] pos;
        pos = '0;
        if (slot <= LAST_SLOT) begin
            pos = POS_TABLE[slot[POS_W-1:0]];
        end
        return pos;
    endfunction

endpackage

/* rtl/lfbc_front.sv */
// Front end: takes requests, drops set-colour and place requests for slots above 24,
// looks up the pixel position and hands a decoded command to the queue. Uses lfbc_pkg.
module lfbc_front (
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lfbc_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [lfbc_pkg::SLOT_W-1:0]   i_slot,
    input  logic [lfbc_pkg::CHAN_W-1:0]   i_red_in,
    input  logic [lfbc_pkg::CHAN_W-1:0]   i_green_in,
    input  logic [lfbc_pkg::CHAN_W-1:0]   i_blue_in,
    input  logic                          i_q_full,
    output logic                          o_push,
    output lfbc_pkg::t_cmd                o_cmd
);

    logic w_slot_bad;
    logic w_drop;

    assign o_ready    = i_rst_n && !i_q_full;
    assign w_slot_bad = i_slot > lfbc_pkg::LAST_SLOT;

    always_comb begin
        o_cmd.slot  = i_slot;
        o_cmd.pos   = lfbc_pkg::position_of(i_slot);
        o_cmd.color = {i_red_in, i_green_in, i_blue_in};
        w_drop      = 1'b0;
        unique case (i_opcode)
            lfbc_pkg::OP_SET_COLOR: begin
                o_cmd.kind = lfbc_pkg::KIND_SET;
                w_drop     = w_slot_bad;
            end
            lfbc_pkg::OP_ADVANCE: begin
                o_cmd.kind = lfbc_pkg::KIND_ADVANCE;
            end
            lfbc_pkg::OP_PLACE: begin
                o_cmd.kind = lfbc_pkg::KIND_PLACE;
                w_drop     = w_slot_bad;
            end
            default: begin
                o_cmd.kind = lfbc_pkg::KIND_TICK;
            end
        endcase
    end

    assign o_push = i_rst_n && i_valid && o_ready && !w_drop;

endmodule

/* rtl/lfbc_queue.sv */
// Short command queue between the front end and the back end.
// Holds decoded commands of type lfbc_pkg::t_cmd; depth comes from lfbc_pkg.
module lfbc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lfbc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output lfbc_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (lfbc_pkg::QUEUE_DEPTH > 1) ? $clog2(lfbc_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lfbc_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(lfbc_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(lfbc_pkg::QUEUE_DEPTH);

    lfbc_pkg::t_cmd    r_entry [lfbc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              w_push, w_pop;

    assign o_full  = r_count == CNT_FULL;
    assign o_valid = r_count != '0;
    assign o_cmd   = r_entry[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* rtl/lfbc_back.sv */
// Back end: owns the pixel store, the cursor and the blink phase, executes queued
// commands and streams the frame through a read stage and an output register. Uses lfbc_pkg.
module lfbc_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  lfbc_pkg::t_cmd              i_q_cmd,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [lfbc_pkg::CHAN_W-1:0] o_pixel_green,
    output logic [lfbc_pkg::CHAN_W-1:0] o_pixel_red,
    output logic [lfbc_pkg::CHAN_W-1:0] o_pixel_blue,
    output logic                        o_frame_last
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_SET      = 7'b0000010,
        ST_MOVE_WR  = 7'b0000100,
        ST_MOVE_RD  = 7'b0001000,
        ST_MOVE_CAP = 7'b0010000,
        ST_TICK_WR  = 7'b0100000,
        ST_STREAM   = 7'b1000000
    } t_state;

    localparam int PW = lfbc_pkg::POS_W;
    localparam int SW = lfbc_pkg::SLOT_W;
    localparam int CW = lfbc_pkg::COLOR_W;

    t_state             r_state, n_state;
    lfbc_pkg::t_cmd     r_cmd;
    logic [SW-1:0]      r_cursor_slot;
    logic [PW-1:0]      r_cur_pos;
    logic               r_phase_on;
    logic [CW-1:0]      r_saved;
    logic [PW-1:0]      r_idx;

    logic [CW-1:0]      r_mem [lfbc_pkg::PIXEL_COUNT];
    logic [lfbc_pkg::PIXEL_COUNT-1:0] r_written;

    logic [CW-1:0]      r_rd_color;
    logic               r_rd_written;
    logic               r_rd_black;
    logic               r_a_valid;
    logic               r_a_last;
    logic [CW-1:0]      r_out_color;
    logic               r_out_valid;
    logic               r_out_last;

    logic               w_wr_en;
    logic [PW-1:0]      w_wr_pos;
    logic [CW-1:0]      w_wr_color;
    logic               w_rd_en;
    logic               w_rd_stream;
    logic [PW-1:0]      w_rd_pos;
    logic [CW-1:0]      w_rd_value;
    logic               w_a_move;
    logic [SW-1:0]      w_new_slot;

    assign w_rd_value = r_rd_written ? r_rd_color :
                        (r_rd_black ? lfbc_pkg::BLACK_RGB : lfbc_pkg::GREY_RGB);
    assign w_a_move    = r_a_valid && (!r_out_valid || i_ready);
    assign w_rd_stream = (r_state == ST_STREAM) && (!r_a_valid || w_a_move);
    assign w_rd_en     = w_rd_stream || ((r_state == ST_MOVE_RD) && !r_a_valid);
    assign w_rd_pos    = (r_state == ST_MOVE_RD) ? r_cur_pos : r_idx;
    assign o_q_pop     = (r_state == ST_IDLE) && i_q_valid;

    always_comb begin
        w_new_slot = r_cmd.slot;
        if (r_cmd.kind == lfbc_pkg::KIND_ADVANCE) begin
            w_new_slot = (r_cursor_slot >= lfbc_pkg::LAST_SLOT) ?
                         lfbc_pkg::FIRST_SLOT : r_cursor_slot + 1'b1;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_wr_en    = 1'b0;
        w_wr_pos   = r_cur_pos;
        w_wr_color = r_saved;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    unique case (i_q_cmd.kind)
                        lfbc_pkg::KIND_SET:     n_state = ST_SET;
                        lfbc_pkg::KIND_ADVANCE: n_state = ST_MOVE_WR;
                        lfbc_pkg::KIND_PLACE:   n_state = ST_MOVE_WR;
                        default:                n_state = ST_TICK_WR;
                    endcase
                end
            end
            ST_SET: begin
                w_wr_en    = 1'b1;
                w_wr_pos   = r_cmd.pos;
                w_wr_color = r_cmd.color;
                n_state    = ST_IDLE;
            end
            ST_MOVE_WR: begin
                w_wr_en = 1'b1;
                n_state = ST_MOVE_RD;
            end
            ST_MOVE_RD: begin
                if (!r_a_valid) begin
                    n_state = ST_MOVE_CAP;
                end
            end
            ST_MOVE_CAP: begin
                n_state = ST_IDLE;
            end
            ST_TICK_WR: begin
                w_wr_en    = 1'b1;
                w_wr_color = r_phase_on ? lfbc_pkg::BLACK_RGB : r_saved;
                n_state    = ST_STREAM;
            end
            ST_STREAM: begin
                if (w_rd_stream && (r_idx == lfbc_pkg::LAST_POS)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cursor_slot <= lfbc_pkg::RESET_SLOT;
            r_cur_pos     <= lfbc_pkg::position_of(lfbc_pkg::RESET_SLOT);
            r_phase_on    <= 1'b1;
            r_saved       <= lfbc_pkg::GREY_RGB;
            r_idx         <= '0;
            r_written     <= '0;
            r_a_valid     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_wr_en) begin
                r_written[w_wr_pos] <= 1'b1;
            end
            if (r_state == ST_MOVE_WR) begin
                r_cursor_slot <= w_new_slot;
                r_cur_pos     <= lfbc_pkg::position_of(w_new_slot);
                r_phase_on    <= 1'b1;
            end
            if (r_state == ST_MOVE_CAP) begin
                r_saved <= w_rd_value;
            end
            if (r_state == ST_TICK_WR) begin
                r_phase_on <= !r_phase_on;
                r_idx      <= '0;
            end else if (w_rd_stream) begin
                r_idx <= r_idx + 1'b1;
            end
            if (w_rd_stream) begin
                r_a_valid <= 1'b1;
            end else if (w_a_move) begin
                r_a_valid <= 1'b0;
            end
            if (w_a_move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        if (w_wr_en) begin
            r_mem[w_wr_pos] <= w_wr_color;
        end
        if (w_rd_en) begin
            r_rd_color   <= r_mem[w_rd_pos];
            r_rd_written <= r_written[w_rd_pos];
            r_rd_black   <= w_rd_pos == lfbc_pkg::LAST_POS;
            r_a_last     <= w_rd_pos == lfbc_pkg::LAST_POS;
        end
        if (w_a_move) begin
            r_out_color <= w_rd_value;
            r_out_last  <= r_a_last;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pixel_red   = r_out_color[CW-1 -: lfbc_pkg::CHAN_W];
    assign o_pixel_green = r_out_color[CW-1-lfbc_pkg::CHAN_W -: lfbc_pkg::CHAN_W];
    assign o_pixel_blue  = r_out_color[lfbc_pkg::CHAN_W-1:0];
    assign o_frame_last  = r_out_last;

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor_slot <= lfbc_pkg::LAST_SLOT)
        else $error("cursor slot out of range");

    a_cursor_pos_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_pos == lfbc_pkg::position_of(r_cursor_slot))
        else $error("cursor position does not follow cursor slot");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=>
        (r_out_valid && $stable(r_out_color) && $stable(r_out_last)))
        else $error("stalled pixel changed before it was taken");

    a_move_read_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE_CAP) |-> !r_a_valid)
        else $error("cursor read overlapped a streamed pixel");

endmodule

/* rtl/led_frame_with_blink_cursor.sv */
// LED frame store with a blinking cursor over 25 hour slots: top level.
// Instantiates lfbc_front, lfbc_queue and lfbc_back; uses lfbc_pkg.
//
// Requests arrive on i_in_valid / o_in_ready with an opcode, a slot and an RGB colour.
// Set-colour and place requests for slots above 24 are accepted and discarded.
// Only the blink tick produces results: 25 pixels on o_out_valid / i_out_ready in
// position order, green, red and blue bytes, with o_frame_last on the final pixel.
// The front end decodes a request in the cycle it is accepted and places it in a
// two-entry queue; the back end then handles set-colour in a write state, advance
// or place in write, read and capture states, and a tick as a write of the cursor
// pixel, then one pixel per cycle from the single read port of the pixel store
// while the receiver does not stall. After the cursor write, the pixels of a tick
// pass the read stage and the output register. A stalled receiver holds the output
// register and the read stage behind it; the queue then fills and o_in_ready falls.
// Reset restores grey 124 on every pixel but position 24, which is black, puts the
// cursor on slot 1 with its blink phase on and its saved colour grey; this takes
// effect at once through per-entry written flags, with no clearing pass.
module led_frame_with_blink_cursor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [lfbc_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [lfbc_pkg::SLOT_W-1:0]   i_slot,
    input  logic [lfbc_pkg::CHAN_W-1:0]   i_red_in,
    input  logic [lfbc_pkg::CHAN_W-1:0]   i_green_in,
    input  logic [lfbc_pkg::CHAN_W-1:0]   i_blue_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [lfbc_pkg::CHAN_W-1:0]   o_pixel_green,
    output logic [lfbc_pkg::CHAN_W-1:0]   o_pixel_red,
    output logic [lfbc_pkg::CHAN_W-1:0]   o_pixel_blue,
    output logic                          o_frame_last
);

    logic           w_q_full;
    logic           w_push;
    lfbc_pkg::t_cmd w_push_cmd;
    logic           w_q_valid;
    logic           w_q_pop;
    lfbc_pkg::t_cmd w_q_cmd;

    lfbc_front u_front (
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .o_ready    (o_in_ready),
        .i_opcode   (i_opcode),
        .i_slot     (i_slot),
        .i_red_in   (i_red_in),
        .i_green_in (i_green_in),
        .i_blue_in  (i_blue_in),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    lfbc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_cmd   (w_q_cmd)
    );

    lfbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_cmd       (w_q_cmd),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_pixel_green (o_pixel_green),
        .o_pixel_red   (o_pixel_red),
        .o_pixel_blue  (o_pixel_blue),
        .o_frame_last  (o_frame_last)
    );

endmodule
